// ===== rtl/sector_check_verifier_assert.svh =====
// ----------------------------------------------------------------------------
// Sector check verifier assertion macros
// Concurrent assertion helpers used by the top level of the sector check block.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CHECK_VERIFIER_ASSERT_SVH
`define SECTOR_CHECK_VERIFIER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define SCV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sector check assertion failed");

// Check a consequent in the cycle after its antecedent
`define SCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sector check assertion failed");

`endif

// ===== rtl/scv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sector check verifier package
// Types, codes and per-byte check functions shared by the sector check RTL.
// ----------------------------------------------------------------------------
package scv_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CHECK_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CRC_INIT   = 1'b1;

    // Check modes
    localparam logic [2:0] MODE_CCITT     = 3'd0;
    localparam logic [2:0] MODE_CCITT_REV = 3'd1;
    localparam logic [2:0] MODE_SHIFT_IN  = 3'd2;
    localparam logic [2:0] MODE_SUM16     = 3'd3;
    localparam logic [2:0] MODE_XOR_ROT   = 3'd4;
    localparam logic [2:0] MODE_CSUM8     = 3'd5;

    // Verdict codes
    localparam logic [1:0] STATUS_PASS      = 2'd0;
    localparam logic [1:0] STATUS_FAIL      = 2'd1;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
    localparam logic [1:0] STATUS_UNUSED    = 2'd3;

    localparam logic [15:0] CRC_INIT_RESET = 16'hffff;
    localparam logic [15:0] POLY_SHIFT_IN  = 16'h8005;

    // One sector byte with its end flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } scv_item_t;

    // Configuration as seen by the check core
    typedef struct packed {
        logic [2:0]  check_mode;
        logic [15:0] crc_init;
    } scv_cfg_t;

    // Bit-reverse one byte
    function automatic logic [7:0] reverse8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

    // Bytewise CRC-16-CCITT update
    function automatic logic [15:0] ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'b0000, x[7:4]};
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
            ^ {8'h00, x};
    endfunction

    // Bitwise shift-in CRC over one byte, msb first
    function automatic logic [15:0] shift_in_byte(input logic [15:0] crc,
                                                  input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15];
            c  = {c[14:0], b[i]} ^ (fb ? POLY_SHIFT_IN : 16'h0000);
        end
        return c;
    endfunction

endpackage

// ===== rtl/scv_byte_if.sv =====
// ----------------------------------------------------------------------------
// Sector byte channel
// Valid/ready channel carrying one sector byte and its end flag per beat.
// ----------------------------------------------------------------------------
interface scv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== rtl/scv_status_if.sv =====
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel carrying one sector verdict per beat.
// ----------------------------------------------------------------------------
interface scv_status_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

// ===== rtl/scv_in_stage.sv =====
// ----------------------------------------------------------------------------
// Sector check input stage
// Registers each incoming byte beat; frees itself when the core consumes it.
// ----------------------------------------------------------------------------
module scv_in_stage
    import scv_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    scv_byte_if.sink       sector,
    input  logic           advance,
    output logic           item_valid,
    output scv_item_t      item
);

    logic      vld_reg;
    logic      vld_next;
    scv_item_t item_reg;
    scv_item_t item_next;
    logic      take;

    // Accept a beat when empty or when the held beat moves on this cycle
    assign sector.ready = !vld_reg || advance;
    assign take         = sector.valid && sector.ready;

    always_comb
    begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (sector.ready)
        begin
            vld_next = sector.valid;
        end
        if (take)
        begin
            item_next.data_byte = sector.data_byte;
            item_next.last      = sector.last;
        end
    end

    // Hold valid under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/scv_check_core.sv =====
// ----------------------------------------------------------------------------
// Sector check core
// Per-sector running check state, one-byte update and verdict logic.
// ----------------------------------------------------------------------------
module scv_check_core
    import scv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scv_cfg_t   cfg,
    input  logic       step,
    input  scv_item_t  item,
    output logic [1:0] status
);

    logic [7:0]  held0_reg;
    logic [7:0]  held0_next;
    logic [7:0]  held1_reg;
    logic [7:0]  held1_next;
    logic [15:0] run_reg;
    logic [15:0] run_next;
    logic        carry_reg;
    logic        carry_next;
    logic [1:0]  seen_reg;
    logic [1:0]  seen_next;

    logic [15:0] run;
    logic        carry;
    logic [8:0]  sum9;
    logic [7:0]  rot_in;
    logic        first_byte;
    logic        two_held;

    assign first_byte = (seen_reg == 2'd0);
    assign two_held   = seen_reg[1];

    // Seed at the sector's first byte, then apply the selected per-byte update
    always_comb
    begin
        run    = first_byte ? ((cfg.check_mode <= MODE_SUM16) ? cfg.crc_init : 16'h0000)
                            : run_reg;
        carry  = first_byte ? 1'b0 : carry_reg;
        sum9   = {1'b0, run[7:0]} + {1'b0, held0_reg} + {8'h00, carry};
        rot_in = run[7:0] ^ held0_reg;
        case (cfg.check_mode)
            MODE_CCITT:
            begin
                run = ccitt_byte(run, item.data_byte);
            end
            MODE_CCITT_REV:
            begin
                run = ccitt_byte(run, reverse8(item.data_byte));
            end
            MODE_SHIFT_IN:
            begin
                if (two_held)
                begin
                    run = shift_in_byte(run, held1_reg);
                end
            end
            MODE_SUM16:
            begin
                if (two_held)
                begin
                    run = run + {8'h00, held1_reg};
                end
            end
            MODE_XOR_ROT:
            begin
                if (two_held)
                begin
                    run = {8'h00, rot_in[6:0], rot_in[7]};
                end
            end
            MODE_CSUM8:
            begin
                if (!first_byte)
                begin
                    run   = {8'h00, sum9[7:0]};
                    carry = sum9[8];
                end
            end
            default:
            begin
                run = run;
            end
        endcase
    end

    // Judge the sector on its last byte
    always_comb
    begin
        case (cfg.check_mode)
            MODE_CCITT, MODE_CCITT_REV:
            begin
                status = (run == 16'h0000) ? STATUS_PASS : STATUS_FAIL;
            end
            MODE_SHIFT_IN:
            begin
                if (first_byte)
                begin
                    status = STATUS_TOO_SHORT;
                end
                else
                begin
                    status = (run == 16'h0000) ? STATUS_PASS : STATUS_FAIL;
                end
            end
            MODE_SUM16:
            begin
                if (first_byte)
                begin
                    status = STATUS_TOO_SHORT;
                end
                else
                begin
                    status = (run == {item.data_byte, held0_reg}) ? STATUS_PASS
                                                                  : STATUS_FAIL;
                end
            end
            MODE_XOR_ROT:
            begin
                status = (run[7:0] == item.data_byte) ? STATUS_PASS : STATUS_FAIL;
            end
            MODE_CSUM8:
            begin
                if (first_byte)
                begin
                    status = STATUS_TOO_SHORT;
                end
                else
                begin
                    status = (run[7:0] == item.data_byte) ? STATUS_PASS : STATUS_FAIL;
                end
            end
            default:
            begin
                status = STATUS_FAIL;
            end
        endcase
    end

    // Advance the delay line and count; drop the sector after its last byte
    always_comb
    begin
        held0_next = held0_reg;
        held1_next = held1_reg;
        run_next   = run_reg;
        carry_next = carry_reg;
        seen_next  = seen_reg;
        if (step)
        begin
            run_next = run;
            if (item.last)
            begin
                held0_next = 8'h00;
                held1_next = 8'h00;
                carry_next = 1'b0;
                seen_next  = 2'd0;
            end
            else
            begin
                held0_next = item.data_byte;
                held1_next = held0_reg;
                carry_next = carry;
                seen_next  = (seen_reg == 2'd3) ? seen_reg : seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            run_reg   <= CRC_INIT_RESET;
            carry_reg <= 1'b0;
            seen_reg  <= 2'd0;
        end
        else
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            run_reg   <= run_next;
            carry_reg <= carry_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ===== rtl/sector_check_verifier.sv =====
// ----------------------------------------------------------------------------
// Sector check verifier
// Checks one disk sector per byte stream and gives a pass, fail or too-short
// verdict on the sector's last byte under one of six check schemes.
//
//   channel   dir   beat payload          notes
//   sector    in    data_byte[7:0], last  one sector byte per beat
//   verdict   out   status[1:0]           one beat per sector
//   cfg       in    cfg_index, cfg_data   write strobe cfg_we, no read-back
//
// One byte per cycle, sustained, while no last byte stalls. An accepted byte sits in
// the input register; when it moves on, the check core updates its state and, for a
// last byte, the verdict is loaded into the output register at that same edge.
// Reset clears all control and per-sector state; no clearing pass is needed.
// Only a last byte stalls: it waits in the input register while an earlier
// verdict is still held on the output, and sector.ready drops behind it.
// ----------------------------------------------------------------------------
module sector_check_verifier
    import scv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    scv_byte_if.sink               sector,
    scv_status_if.source           verdict
);

    `include "sector_check_verifier_assert.svh"

    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic [15:0] init_reg;
    logic [15:0] init_next;
    logic        out_vld_reg;
    logic        out_vld_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;

    scv_cfg_t    cfg;
    scv_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        verdict_now;
    logic [1:0]  status;

    // Take configuration writes
    always_comb
    begin
        mode_next = mode_reg;
        init_next = init_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_CHECK_MODE: mode_next = cfg_data[2:0];
                CFG_IDX_CRC_INIT:   init_next = cfg_data;
                default:            mode_next = mode_reg;
            endcase
        end
    end

    assign cfg.check_mode = mode_reg;
    assign cfg.crc_init   = init_reg;

    // Move the held byte on unless it is a last byte facing a full output
    assign advance     = item_valid && (!item.last || !out_vld_reg || verdict.ready);
    assign verdict_now = advance && item.last;

    scv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .sector     (sector),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    scv_check_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (item),
        .status (status)
    );

    // Load the verdict register; drop valid once the beat is taken
    always_comb
    begin
        out_vld_next = out_vld_reg;
        status_next  = status_reg;
        if (verdict_now)
        begin
            out_vld_next = 1'b1;
            status_next  = status;
        end
        else if (verdict.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CCITT;
            init_reg    <= CRC_INIT_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            init_reg    <= init_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign verdict.valid  = out_vld_reg;
    assign verdict.status = status_reg;

    // A processed last byte always leaves a verdict on the output
    `SCV_ASSERT_NEXT(a_verdict_follows_last, clk, rst_n, verdict_now, verdict.valid)
    // A shown verdict never carries the unused code
    `SCV_ASSERT_NOW(a_status_code, clk, rst_n, verdict.valid, verdict.status != STATUS_UNUSED)
    // A blocked input register refuses new beats
    `SCV_ASSERT_NOW(a_hold_blocks_input, clk, rst_n, item_valid && !advance, !sector.ready)

endmodule

// ===== test/sector_check_verifier_checker.sv =====
// ----------------------------------------------------------------------------
// Sector check verdict checker
// Watches the config port and both channels of the sector check block,
// predicts the verdict of every sector from the accepted bytes and compares
// each verdict beat with the oldest prediction.
// ----------------------------------------------------------------------------
module sector_check_verifier_checker
    import scv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    scv_byte_if                    sector,
    scv_status_if                  verdict,
    output int                     mismatches,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the configuration registers
    logic [2:0]  mode_reg;
    logic [15:0] init_reg;

    // Per-sector state: two-byte delay line, running value, carry, byte count
    logic [7:0]  held_new;
    logic [7:0]  held_old;
    logic [15:0] check_acc;
    logic        carry;
    logic [1:0]  seen;

    logic [1:0]  verdict_queue[$];
    logic [1:0]  want;
    int          error_count;
    int          pending_count;

    assign mismatches = error_count;
    assign pending    = pending_count;

    function automatic logic [7:0] mirror_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] ccitt_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return (crc << 8) ^ ({8'h00, x} << 12) ^ ({8'h00, x} << 5) ^ {8'h00, x};
    endfunction

    function automatic logic [15:0] shift_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15];
            r  = {r[14:0], b[i]} ^ (fb ? POLY_SHIFT_IN : 16'h0000);
        end
        return r;
    endfunction

    task automatic report(input string what);
        $display("%0t ns: verdict mismatch: %s", $time, what);
        error_count++;
    endtask

    // Advance the sector state by one accepted byte; queue a verdict on the last one
    task automatic take_byte(input logic [7:0] b, input logic is_last);
        logic [15:0] acc;
        logic        cy;
        logic [8:0]  total;
        logic [7:0]  v;
        logic [1:0]  status;
        logic        opening;
        opening = (seen == 2'd0);
        if (opening)
        begin
            acc = (mode_reg <= MODE_SUM16) ? init_reg : 16'h0000;
            cy  = 1'b0;
        end
        else
        begin
            acc = check_acc;
            cy  = carry;
        end

        case (mode_reg)
            MODE_CCITT:     acc = ccitt_step(acc, b);
            MODE_CCITT_REV: acc = ccitt_step(acc, mirror_byte(b));
            MODE_SHIFT_IN:  if (seen >= 2'd2) acc = shift_step(acc, held_old);
            MODE_SUM16:     if (seen >= 2'd2) acc = acc + {8'h00, held_old};
            MODE_XOR_ROT:
                if (seen >= 2'd2)
                begin
                    v   = acc[7:0] ^ held_new;
                    acc = {8'h00, v[6:0], v[7]};
                end
            MODE_CSUM8:
                if (seen >= 2'd1)
                begin
                    total = {1'b0, acc[7:0]} + {1'b0, held_new} + {8'h00, cy};
                    acc   = {8'h00, total[7:0]};
                    cy    = total[8];
                end
            default: ;
        endcase

        if (is_last)
        begin
            case (mode_reg)
                MODE_CCITT, MODE_CCITT_REV:
                    status = (acc == 16'h0000) ? STATUS_PASS : STATUS_FAIL;
                MODE_SHIFT_IN:
                    status = opening ? STATUS_TOO_SHORT
                           : (acc == 16'h0000) ? STATUS_PASS : STATUS_FAIL;
                MODE_SUM16:
                    status = opening ? STATUS_TOO_SHORT
                           : (acc == {b, held_new}) ? STATUS_PASS : STATUS_FAIL;
                MODE_XOR_ROT:
                    status = (acc[7:0] == b) ? STATUS_PASS : STATUS_FAIL;
                MODE_CSUM8:
                    status = opening ? STATUS_TOO_SHORT
                           : (acc[7:0] == b) ? STATUS_PASS : STATUS_FAIL;
                default:
                    status = STATUS_FAIL;
            endcase
            verdict_queue.push_back(status);
            held_new  = 8'h00;
            held_old  = 8'h00;
            carry     = 1'b0;
            seen      = 2'd0;
            check_acc = (mode_reg <= MODE_SUM16) ? init_reg : 16'h0000;
        end
        else
        begin
            check_acc = acc;
            carry     = cy;
            held_old  = held_new;
            held_new  = b;
            if (seen != 2'd3)
                seen = seen + 2'd1;
        end
    endtask

    // Sample config writes and handshakes at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      = MODE_CCITT;
            init_reg      = CRC_INIT_RESET;
            held_new      = 8'h00;
            held_old      = 8'h00;
            carry         = 1'b0;
            seen          = 2'd0;
            check_acc     = CRC_INIT_RESET;
            error_count   = 0;
            verdict_queue.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_CHECK_MODE: mode_reg = cfg_data[2:0];
                    CFG_IDX_CRC_INIT:   init_reg = cfg_data[15:0];
                    default: ;
                endcase
            end

            if (verdict.valid && verdict.ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    report($sformatf("status %0d with no sector closed", verdict.status));
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (verdict.status !== want)
                        report($sformatf("status %0d, predicted %0d", verdict.status, want));
                end
            end

            if (sector.valid && sector.ready)
                take_byte(sector.data_byte, sector.last);

            pending_count = verdict_queue.size();
        end
    end

endmodule

// ===== test/sector_check_verifier_test.sv =====
// ----------------------------------------------------------------------------
// Sector check verifier testbench
// Feeds sector byte streams to the block under all check modes and varied register
// settings: a directed opening with short sectors, unused modes and a mode
// change inside a sector, then mostly well-formed random sectors with some
// corrupted and noise sectors, under varying sender gaps and verdict stalls.
// ----------------------------------------------------------------------------
module sector_check_verifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scv_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int SEGMENT_BEATS  = 41;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    scv_byte_if   sector();
    scv_status_if verdict();

    int mismatches;
    int pending;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // Register values as last written, used to build well-formed sectors
    logic [2:0]  cur_mode;
    logic [15:0] cur_init;
    logic [7:0]  sector_buf[$];

    sector_check_verifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sector    (sector),
        .verdict   (verdict)
    );

    sector_check_verifier_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sector     (sector),
        .verdict    (verdict),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Drive verdict ready: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            verdict.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            verdict.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // End the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sector.valid && sector.ready) || (verdict.valid && verdict.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sector_check_verifier_test: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [7:0] random_byte();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic logic [7:0] flip_bits(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return (crc << 8) ^ ({8'h00, x} << 12) ^ ({8'h00, x} << 5) ^ {8'h00, x};
    endfunction

    function automatic logic [15:0] shift_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15];
            r  = {r[14:0], b[i]} ^ (fb ? POLY_SHIFT_IN : 16'h0000);
        end
        return r;
    endfunction

    // Offer one byte beat; returns at the edge where it is accepted
    task automatic push_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            sector.valid <= 1'b0;
            @(posedge clk);
        end
        sector.valid     <= 1'b1;
        sector.data_byte <= b;
        sector.last      <= is_last;
        @(negedge clk);
        while (!sector.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic push_sector();
        for (int i = 0; i < sector_buf.size(); i++)
            push_byte(sector_buf[i], i == sector_buf.size() - 1);
    endtask

    // Drop valid, wait for all verdicts, then let the core finish its last update
    task automatic quiesce();
        sector.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == CFG_IDX_CHECK_MODE)
            cur_mode = value[2:0];
        else
            cur_init = value;
    endtask

    task automatic configure(input logic [2:0] mode, input logic [15:0] init);
        quiesce();
        write_reg(CFG_IDX_CHECK_MODE, {13'd0, mode});
        write_reg(CFG_IDX_CRC_INIT, init);
    endtask

    // Append the check bytes that make the bytes in sector_buf a passing sector in a used mode
    task automatic add_tail();
        logic [15:0] acc;
        logic [8:0]  total;
        logic [7:0]  v;
        logic        cy;
        int          n;
        n   = sector_buf.size();
        acc = (cur_mode <= MODE_SUM16) ? cur_init : 16'h0000;
        cy  = 1'b0;
        case (cur_mode)
            MODE_CCITT:
            begin
                for (int i = 0; i < n; i++)
                    acc = ccitt_next(acc, sector_buf[i]);
                sector_buf.push_back(acc[15:8]);
                sector_buf.push_back(acc[7:0]);
            end
            MODE_CCITT_REV:
            begin
                for (int i = 0; i < n; i++)
                    acc = ccitt_next(acc, flip_bits(sector_buf[i]));
                sector_buf.push_back(flip_bits(acc[15:8]));
                sector_buf.push_back(flip_bits(acc[7:0]));
            end
            MODE_SHIFT_IN:
            begin
                // two more bytes clear the register; the final two are not covered
                for (int i = 0; i < n; i++)
                    acc = shift_next(acc, sector_buf[i]);
                acc = shift_next(shift_next(acc, 8'h00), 8'h00);
                sector_buf.push_back(acc[15:8]);
                sector_buf.push_back(acc[7:0]);
                sector_buf.push_back(random_byte());
                sector_buf.push_back(random_byte());
            end
            MODE_SUM16:
            begin
                for (int i = 0; i < n; i++)
                    acc = acc + {8'h00, sector_buf[i]};
                sector_buf.push_back(acc[7:0]);
                sector_buf.push_back(acc[15:8]);
            end
            MODE_XOR_ROT:
            begin
                // the first byte is not covered
                for (int i = 1; i < n; i++)
                begin
                    v   = acc[7:0] ^ sector_buf[i];
                    acc = {8'h00, v[6:0], v[7]};
                end
                sector_buf.push_back(acc[7:0]);
            end
            MODE_CSUM8:
            begin
                for (int i = 0; i < n; i++)
                begin
                    total = {1'b0, acc[7:0]} + {1'b0, sector_buf[i]} + {8'h00, cy};
                    acc   = {8'h00, total[7:0]};
                    cy    = total[8];
                end
                sector_buf.push_back(acc[7:0]);
            end
            default:
                sector_buf.push_back(random_byte());
        endcase
    endtask

    // Mostly passing sectors, some with one bit flipped, some pure noise
    task automatic random_sector();
        int         roll;
        int         len;
        int         spot;
        logic [7:0] mask;
        roll = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        sector_buf.delete();
        for (int i = 0; i < len; i++)
            sector_buf.push_back(random_byte());
        if (roll < 88)
            add_tail();
        else
            sector_buf.push_back(random_byte());
        if (roll >= 70 && roll < 88)
        begin
            spot = $urandom_range(0, sector_buf.size() - 1);
            mask = 8'h01 << $urandom_range(0, 7);
            sector_buf[spot] = sector_buf[spot] ^ mask;
        end
    endtask

    initial
    begin
        int          beats;
        int          seg_no;
        logic [15:0] init;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        sector.valid     = 1'b0;
        sector.data_byte = 8'h00;
        sector.last      = 1'b0;
        verdict.ready    = 1'b0;
        cur_mode         = MODE_CCITT;
        cur_init         = CRC_INIT_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a one-byte sector, then a good one over byte extremes
        push_byte(8'hff, 1'b1);
        sector_buf = '{8'h00, 8'hff};
        add_tail();
        push_sector();

        configure(MODE_CCITT_REV, 16'h0000);
        sector_buf = '{8'ha5};
        add_tail();
        push_sector();

        // Short sectors report too short in shift-in, sum16 and carry-sum modes
        configure(MODE_SHIFT_IN, 16'hffff);
        push_byte(8'h80, 1'b1);
        sector_buf = '{8'h01};
        add_tail();
        push_sector();

        configure(MODE_SUM16, 16'h1234);
        push_byte(8'h00, 1'b1);
        sector_buf.delete();
        add_tail();
        push_sector();

        configure(MODE_XOR_ROT, 16'hffff);
        push_byte(8'h00, 1'b1);
        sector_buf = '{8'hff, 8'h81, 8'h7e};
        add_tail();
        push_sector();

        configure(MODE_CSUM8, 16'hffff);
        push_byte(8'hff, 1'b1);
        sector_buf = '{8'hff, 8'hff};
        add_tail();
        push_sector();

        // Unused modes always fail
        configure(MODE_SPARE_A, 16'h0000);
        push_byte(8'h11, 1'b1);
        configure(MODE_SPARE_B, 16'hffff);
        push_byte(8'h33, 1'b1);

        // Switch mode and seed in the middle of a sector
        configure(MODE_CCITT, 16'hffff);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        quiesce();
        write_reg(CFG_IDX_CHECK_MODE, {13'd0, MODE_CSUM8});
        write_reg(CFG_IDX_CRC_INIT, 16'h0000);
        push_byte(8'h56, 1'b0);
        push_byte(8'h78, 1'b1);

        // Random sectors: four idling phases, four register settings each
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1) ? 56 : (phase == 3) ? 30 : 0;
            stall_pct = (phase == 2) ? 56 : (phase == 3) ? 30 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                seg_no = phase * 4 + seg;
                init   = (seg_no % 3 == 0) ? 16'h0000
                       : (seg_no % 3 == 1) ? 16'hffff : 16'($urandom_range(0, 65535));
                configure(seg_no[2:0], init);

                // Hold verdicts off while one-byte sectors keep coming
                if (phase == 0 && seg == 1)
                begin
                    hold_request = HOLD_CYCLES;
                    for (int k = 0; k < 24; k++)
                        push_byte(random_byte(), 1'b1);
                end

                beats = 0;
                while (beats < SEGMENT_BEATS)
                begin
                    random_sector();
                    push_sector();
                    beats += sector_buf.size();
                end
            end
        end

        sector.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("sector_check_verifier_test: done, clean");
        else
            $display("sector_check_verifier_test: done, errors");
        $finish;
    end

endmodule
